// ----- design/rnt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnt_pkg
// Shared types and codes of the RSSI neighbor table: the stored entry layout,
// the result outcome codes and the configuration register indexes.
// ----------------------------------------------------------------------------
package rnt_pkg;

	typedef struct packed {
		logic [47:0]        addr;
		logic signed [7:0]  strength;
		logic [31:0]        seen;
	} entry_t;

	typedef logic [2:0] outcome_t;

	localparam outcome_t OC_SELF           = 3'd0;
	localparam outcome_t OC_WEAK_UNKNOWN   = 3'd1;
	localparam outcome_t OC_WEAK_REFRESHED = 3'd2;
	localparam outcome_t OC_UPDATED        = 3'd3;
	localparam outcome_t OC_ADDED          = 3'd4;
	localparam outcome_t OC_REPLACED       = 3'd5;
	localparam outcome_t OC_DROPPED        = 3'd6;
	localparam outcome_t OC_CLEANUP        = 3'd7;

	localparam logic [1:0] REG_OWN_MAC    = 2'd0;
	localparam logic [1:0] REG_THRESHOLD  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT    = 2'd2;

	localparam logic [47:0]       OWN_MAC_RESET   = 48'd0;
	localparam logic signed [7:0] THRESHOLD_RESET = -8'sd80;
	localparam logic [31:0]       TIMEOUT_RESET   = 32'd5000;

endpackage

// ----- design/rnt_entry_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnt_entry_ram
// Simple dual-port entry memory: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rnt_entry_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  rnt_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output rnt_pkg::entry_t rdata
);

	rnt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/rssi_neighbor_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_neighbor_table_top
// Table of heard neighbors with address, signal strength and last-seen time,
// updated by observations and aged out by cleanup ticks.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: tuser carries the opcode (observation
// or cleanup tick), tdata the address, strength and current time. Each input
// transfer yields exactly one result on the m_ stream with the outcome, the
// slot touched, the number of freed entries and the active count.
// The entries live in a synchronous memory; the active bits sit in flops.
// An item reads every entry once, one per cycle, then decides and writes
// back at most one entry and loads its result; the block takes no new item
// until the previous result has been loaded.
// Reset clears all active bits, the active count and the handshake state,
// and loads the register defaults. If the receiver stalls, the result waits
// in the output register; the next item is accepted and processed, and it
// holds in its final step until the output register frees up.
// Configuration writes take effect at once; they are to be made while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module rssi_neighbor_table_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // mac[47:0], rssi[55:48], now_ms[87:56]
	input  logic        s_tuser,   // opcode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // outcome[2:0], slot[6:3], removed_count[11:7],
	                               // active_count[16:12], zero fill above
);

	import rnt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [47:0]       own_mac_q;
	logic signed [7:0] thr_q;
	logic [31:0]       timeout_q;

	// captured item
	logic              opcode_q;
	logic [47:0]       mac_q;
	logic signed [7:0] rssi_q;
	logic [31:0]       now_q;

	// scan control and results
	logic [IW-1:0]           idx_q;
	logic                    rd_vld_s1;
	logic [IW-1:0]           rd_idx_s1;
	logic [TABLE_ENTRIES-1:0] active_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           removed_q;
	logic                    hit_found_q;
	logic [IW-1:0]           hit_idx_q;
	logic signed [7:0]       hit_str_q;
	logic                    free_found_q;
	logic [IW-1:0]           free_idx_q;
	logic [IW-1:0]           weak_idx_q;
	logic signed [7:0]       weak_str_q;

	// decision results
	outcome_t      res_outcome_q;
	logic [IW-1:0] res_slot_q;

	entry_t rd_entry;

	// decision logic
	outcome_t      dec_outcome;
	logic          dec_write;
	logic          dec_add;
	logic [IW-1:0] dec_idx;
	entry_t        dec_entry;

	logic          cur_active;
	logic          cur_match;
	logic [31:0]   cur_age;
	logic          cur_expired;
	logic [6:0]    slot_wide;
	logic [6:0]    removed_wide;
	logic [6:0]    active_wide;

	assign s_tready = (state_q == ST_IDLE);

	rnt_entry_ram #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (state_q == ST_DECIDE && dec_write),
		.waddr(dec_idx),
		.wdata(dec_entry),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	always_comb begin
		cur_active  = active_q[rd_idx_s1];
		cur_match   = cur_active && (rd_entry.addr == mac_q);
		cur_age     = now_q - rd_entry.seen;
		cur_expired = cur_active && (cur_age > timeout_q);
	end

	always_comb begin
		dec_outcome = OC_CLEANUP;
		dec_write   = 1'b0;
		dec_add     = 1'b0;
		dec_idx     = hit_idx_q;
		dec_entry   = '{addr: mac_q, strength: rssi_q, seen: now_q};
		if (opcode_q) begin
			dec_outcome = OC_CLEANUP;
		end else if (mac_q == own_mac_q) begin
			dec_outcome = OC_SELF;
		end else if (rssi_q < thr_q) begin
			if (hit_found_q) begin
				dec_outcome        = OC_WEAK_REFRESHED;
				dec_write          = 1'b1;
				dec_entry.strength = hit_str_q;
			end else begin
				dec_outcome = OC_WEAK_UNKNOWN;
			end
		end else if (hit_found_q) begin
			dec_outcome = OC_UPDATED;
			dec_write   = 1'b1;
		end else if (free_found_q) begin
			dec_outcome = OC_ADDED;
			dec_write   = 1'b1;
			dec_add     = 1'b1;
			dec_idx     = free_idx_q;
		end else if (rssi_q > weak_str_q) begin
			dec_outcome = OC_REPLACED;
			dec_write   = 1'b1;
			dec_idx     = weak_idx_q;
		end else begin
			dec_outcome = OC_DROPPED;
		end
	end

	// Results are masked to their field widths for wide tables.
	assign slot_wide    = 7'(res_slot_q);
	assign removed_wide = 7'(removed_q);
	assign active_wide  = 7'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			own_mac_q     <= OWN_MAC_RESET;
			thr_q         <= THRESHOLD_RESET;
			timeout_q     <= TIMEOUT_RESET;
			idx_q         <= '0;
			rd_vld_s1     <= 1'b0;
			rd_idx_s1     <= '0;
			active_q      <= '0;
			cnt_q         <= '0;
			removed_q     <= '0;
			hit_found_q   <= 1'b0;
			hit_idx_q     <= '0;
			hit_str_q     <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			weak_idx_q    <= '0;
			weak_str_q    <= '0;
			res_outcome_q <= OC_SELF;
			res_slot_q    <= '0;
			m_tvalid      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_OWN_MAC:   own_mac_q <= cfg_wdata;
					REG_THRESHOLD: thr_q     <= cfg_wdata[7:0];
					REG_TIMEOUT:   timeout_q <= cfg_wdata[31:0];
					default: ;
				endcase
			end

			// A result loaded in the emit state replaces the one leaving.
			if (m_tvalid && m_tready && state_q != ST_EMIT) begin
				m_tvalid <= 1'b0;
			end

			rd_vld_s1 <= (state_q == ST_SCAN);
			rd_idx_s1 <= idx_q;

			// One entry is examined per cycle as its read data returns.
			if (rd_vld_s1) begin
				if (cur_match && !hit_found_q) begin
					hit_found_q <= 1'b1;
					hit_idx_q   <= rd_idx_s1;
					hit_str_q   <= rd_entry.strength;
				end
				if (!cur_active && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= rd_idx_s1;
				end
				if (rd_idx_s1 == '0 || rd_entry.strength < weak_str_q) begin
					weak_idx_q <= rd_idx_s1;
					weak_str_q <= rd_entry.strength;
				end
				if (opcode_q && cur_expired) begin
					active_q[rd_idx_s1] <= 1'b0;
					cnt_q               <= cnt_q - 1'b1;
					removed_q           <= removed_q + 1'b1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q        <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						removed_q    <= '0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (dec_add) begin
						active_q[dec_idx] <= 1'b1;
						cnt_q             <= cnt_q + 1'b1;
					end
					res_outcome_q <= dec_outcome;
					res_slot_q    <= dec_write ? dec_idx : '0;
					state_q       <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			opcode_q <= s_tuser;
			mac_q    <= s_tdata[47:0];
			rssi_q   <= s_tdata[55:48];
			now_q    <= s_tdata[87:56];
		end
		if (state_q == ST_EMIT && (!m_tvalid || m_tready)) begin
			m_tdata <= {7'd0, active_wide[4:0], removed_wide[4:0], slot_wide[3:0],
				res_outcome_q};
		end
	end

endmodule
